FILE: hw/rtl/dtf_pkg.sv
// Shared constants, codes and types of the discrete transfer function block.
// No dependencies; compile this file first.
package dtf_pkg;

   // Largest filter order; every history and coefficient table uses MAX_ORDER+1 entries
   localparam int MAX_ORDER  = 8;
   localparam int IDX_W      = $clog2(MAX_ORDER + 1);
   localparam int ADDR_W     = IDX_W + 1;
   localparam int MEM_DEPTH  = 2 ** ADDR_W;
   localparam int CNT_W      = $clog2(2 * MAX_ORDER + 2);

   localparam int DATA_W     = 32;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int ACC_W      = PROD_W + $clog2(2 * MAX_ORDER + 1) + 1;
   localparam int DIV_CNT_W  = $clog2(DATA_W);

   localparam int CMD_W      = 2;
   localparam int ORDER_IN_W = 4;
   localparam int COEF_IDX_W = 4;
   localparam int STATUS_W   = 3;

   localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // Table select bit on top of the memory address
   localparam logic SEL_B = 1'b0;   // numerator coefficients
   localparam logic SEL_A = 1'b1;   // denominator coefficients
   localparam logic SEL_U = 1'b0;   // input history
   localparam logic SEL_Y = 1'b1;   // output history

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE     = 2'd0,
      CMD_SET_ORDERS = 2'd1,
      CMD_WRITE_COEF = 2'd2,
      CMD_CLEAR      = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_COMPUTED   = 3'd0,
      ST_IDLE       = 3'd1,
      ST_ORDERS_OK  = 3'd2,
      ST_ORDERS_BAD = 3'd3,
      ST_SATURATED  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ADD,
      OP_SUB,
      OP_XB,
      OP_DIV
   } op_type;

   // Tag that travels with each memory read through the multiply-accumulate pipe
   typedef struct packed {
      op_type            op;
      logic              zero;
      logic [ADDR_W-1:0] wr_addr;
   } tag_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MAC,
      S_DRAIN,
      S_PREP,
      S_CHECK,
      S_DIV,
      S_SIGN,
      S_FIN,
      S_DONE
   } state_type;

endpackage

FILE: hw/rtl/dtf_req_if.sv
// Request channel of the discrete transfer function: valid/ready plus command payload.
// Depends on dtf_pkg.
interface dtf_req_if;
   import dtf_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [CMD_W-1:0]             cmd;
   logic                         enable;
   logic signed [DATA_W-1:0]     sample_in;
   logic [ORDER_IN_W-1:0]        num_order_in;
   logic [ORDER_IN_W-1:0]        den_order_in;
   logic                         coef_table;
   logic [COEF_IDX_W-1:0]        coef_index;
   logic signed [DATA_W-1:0]     coef_value;

   modport source (
      output valid, cmd, enable, sample_in, num_order_in, den_order_in,
             coef_table, coef_index, coef_value,
      input  ready
   );

   modport sink (
      input  valid, cmd, enable, sample_in, num_order_in, den_order_in,
             coef_table, coef_index, coef_value,
      output ready
   );
endinterface

FILE: hw/rtl/dtf_rsp_if.sv
// Response channel of the discrete transfer function: valid/ready plus result payload.
// Depends on dtf_pkg.
interface dtf_rsp_if;
   import dtf_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] filter_out;
   logic [STATUS_W-1:0]      status;

   modport source (output valid, filter_out, status, input ready);
   modport sink   (input valid, filter_out, status, output ready);
endinterface

FILE: hw/rtl/discrete_transfer_function.sv
// Direct form I transfer function, Q16.16, one request beat gives one response beat.
// A computing sample issues its memory reads, drains the pipe and runs the bit-serial divider;
// saturation skips the divider. Other beats go straight to the hand-over state. One beat is
// in work at a time; the next is taken once the result has moved into the output register.
// Reset: histories and coefficients read as zero through per-entry valid bits, no sweep.
module discrete_transfer_function (
   input logic      clock,
   input logic      reset,
   dtf_req_if.sink   req_bus,
   dtf_rsp_if.source rsp_bus
);
   import dtf_pkg::*;

   // Control state
   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [IDX_W-1:0]        num_ord_ff, den_ord_ff;
   logic [DIV_CNT_W-1:0]    dcnt_ff;

   // Memories and valid bits
   logic signed [DATA_W-1:0] coef_mem [MEM_DEPTH];
   logic signed [DATA_W-1:0] hist_mem [MEM_DEPTH];
   logic [MEM_DEPTH-1:0]     coef_vld_ff;
   logic [MEM_DEPTH-1:0]     hist_vld_ff;
   logic signed [DATA_W-1:0] coef_rd_ff, hist_rd_ff;
   logic                     coef_rv_ff, hist_rv_ff;
   logic signed [DATA_W-1:0] coef_eff, hist_eff;

   // Datapath
   logic signed [DATA_W-1:0] sample_ff;
   tag_type                  issue_tag, tag1_ff;
   op_type                   tag2_op_ff;
   logic signed [DATA_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [DATA_W-1:0] div_ff;
   logic [ACC_W-1:0]         mag_ff;
   logic [DATA_W-1:0]        dm_ff;
   logic                     aneg_ff, qneg_ff;
   logic [DATA_W-1:0]        rem_ff, quo_ff;
   logic [DATA_W:0]          rem2, rem_diff;
   logic                     rem_ge;

   // Result staging and output register
   logic signed [DATA_W-1:0] res_y_ff, rsp_y_ff;
   status_type               res_st_ff, rsp_st_ff;
   logic                     rsp_valid_ff;

   // Combinational controls
   logic                     req_fire;
   logic [ADDR_W-1:0]        coef_raddr, hist_raddr;
   logic                     hist_we;
   logic [ADDR_W-1:0]        hist_waddr;
   logic signed [DATA_W-1:0] hist_wdata;
   logic                     coef_we, hist_clr, acc_clr, ord_we, rsp_load;
   logic                     prep_go, div_init, div_step;
   logic                     res_load;
   logic signed [DATA_W-1:0] res_y_val;
   status_type               res_st_val;
   logic [CNT_W-1:0]         two_n;
   logic [IDX_W-1:0]         term_i, hist_j;

   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.filter_out = rsp_y_ff;
   assign rsp_bus.status     = rsp_st_ff;

   assign coef_eff = coef_rv_ff ? coef_rd_ff : '0;
   assign hist_eff = hist_rv_ff ? hist_rd_ff : '0;

   assign two_n  = CNT_W'({den_ord_ff, 1'b0});
   assign term_i = IDX_W'(cnt_ff >> 1);
   assign hist_j = IDX_W'(den_ord_ff - term_i - 1'b1);

   // Divider step: shift in next dividend bit, subtract when it fits
   assign rem2     = {rem_ff, quo_ff[DATA_W-1]};
   assign rem_diff = rem2 - {1'b0, dm_ff};
   assign rem_ge   = (rem2 >= {1'b0, dm_ff});

   // Next state, memory issue and write port
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      issue_tag  = '{op: OP_NONE, zero: 1'b0, wr_addr: '0};
      coef_raddr = '0;
      hist_raddr = '0;
      hist_we    = (tag1_ff.op == OP_ADD) || (tag1_ff.op == OP_SUB);
      hist_waddr = tag1_ff.wr_addr;
      hist_wdata = hist_eff;
      coef_we    = 1'b0;
      hist_clr   = 1'b0;
      acc_clr    = 1'b0;
      ord_we     = 1'b0;
      rsp_load   = 1'b0;
      prep_go    = 1'b0;
      div_init   = 1'b0;
      div_step   = 1'b0;
      res_load   = 1'b0;
      res_y_val  = '0;
      res_st_val = ST_IDLE;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_load = 1'b1;
               state_in = S_DONE;
               case (req_bus.cmd)
                  CMD_SAMPLE: begin
                     if (req_bus.enable) begin
                        res_load = 1'b0;
                        acc_clr  = 1'b1;
                        cnt_in   = '0;
                        state_in = S_MAC;
                     end
                  end
                  CMD_SET_ORDERS: begin
                     if (req_bus.num_order_in > MAX_ORDER || req_bus.den_order_in > MAX_ORDER
                         || req_bus.num_order_in > req_bus.den_order_in) begin
                        res_st_val = ST_ORDERS_BAD;
                     end else begin
                        ord_we     = 1'b1;
                        res_st_val = ST_ORDERS_OK;
                     end
                  end
                  CMD_WRITE_COEF: begin
                     coef_we = (req_bus.coef_index <= MAX_ORDER);
                  end
                  CMD_CLEAR: begin
                     hist_clr = 1'b1;
                  end
                  default: begin
                     res_st_val = ST_IDLE;
                  end
               endcase
            end
         end

         // Issue two reads per term, then b[N] for the input term, then a[N]
         S_MAC: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff < two_n) begin
               if (cnt_ff[0]) begin
                  coef_raddr = {SEL_A, term_i};
                  hist_raddr = {SEL_Y, hist_j};
                  issue_tag  = '{op: OP_SUB, zero: 1'b0,
                                 wr_addr: {SEL_Y, IDX_W'(den_ord_ff - term_i)}};
               end else begin
                  coef_raddr = {SEL_B, term_i};
                  hist_raddr = {SEL_U, hist_j};
                  issue_tag  = '{op: OP_ADD, zero: (term_i > num_ord_ff),
                                 wr_addr: {SEL_U, IDX_W'(den_ord_ff - term_i)}};
               end
            end else if (cnt_ff == two_n) begin
               coef_raddr = {SEL_B, den_ord_ff};
               issue_tag  = '{op: OP_XB, zero: (den_ord_ff > num_ord_ff), wr_addr: '0};
            end else begin
               coef_raddr = {SEL_A, den_ord_ff};
               issue_tag  = '{op: OP_DIV, zero: 1'b0, wr_addr: '0};
               cnt_in     = '0;
               state_in   = S_DRAIN;
            end
         end

         // Let the pipe empty; the new input sample takes the freed newest slot
         S_DRAIN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '0) begin
               hist_we    = 1'b1;
               hist_waddr = {SEL_U, IDX_W'(0)};
               hist_wdata = sample_ff;
            end else begin
               state_in = S_PREP;
            end
         end

         S_PREP: begin
            prep_go  = 1'b1;
            state_in = S_CHECK;
         end

         // Catch divide by zero and quotients of 2^32 or more before dividing
         S_CHECK: begin
            if (dm_ff == '0) begin
               res_load   = 1'b1;
               res_y_val  = aneg_ff ? SAT_MIN : SAT_MAX;
               res_st_val = ST_SATURATED;
               state_in   = S_FIN;
            end else if (mag_ff[ACC_W-1:DATA_W] >= (ACC_W-DATA_W)'(dm_ff)) begin
               res_load   = 1'b1;
               res_y_val  = qneg_ff ? SAT_MIN : SAT_MAX;
               res_st_val = ST_SATURATED;
               state_in   = S_FIN;
            end else begin
               div_init = 1'b1;
               state_in = S_DIV;
            end
         end

         S_DIV: begin
            div_step = 1'b1;
            if (dcnt_ff == DIV_CNT_W'(DATA_W - 1)) begin
               state_in = S_SIGN;
            end
         end

         // Apply sign and clamp to the 32-bit range
         S_SIGN: begin
            res_load   = 1'b1;
            res_st_val = ST_COMPUTED;
            if (qneg_ff) begin
               if (quo_ff > DATA_W'(SAT_MIN)) begin
                  res_y_val  = SAT_MIN;
                  res_st_val = ST_SATURATED;
               end else begin
                  res_y_val = -quo_ff;
               end
            end else if (quo_ff[DATA_W-1]) begin
               res_y_val  = SAT_MAX;
               res_st_val = ST_SATURATED;
            end else begin
               res_y_val = quo_ff;
            end
            state_in = S_FIN;
         end

         S_FIN: begin
            hist_we    = 1'b1;
            hist_waddr = {SEL_Y, IDX_W'(0)};
            hist_wdata = res_y_ff;
            state_in   = S_DONE;
         end

         // Hand the result over once the output register is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         num_ord_ff   <= IDX_W'(MAX_ORDER);
         den_ord_ff   <= IDX_W'(MAX_ORDER);
         tag1_ff      <= '{op: OP_NONE, zero: 1'b0, wr_addr: '0};
         tag2_op_ff   <= OP_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         tag1_ff    <= issue_tag;
         tag2_op_ff <= (tag1_ff.op == OP_DIV) ? OP_NONE : tag1_ff.op;
         if (ord_we) begin
            num_ord_ff <= IDX_W'(req_bus.num_order_in);
            den_ord_ff <= IDX_W'(req_bus.den_order_in);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Valid bits: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
         hist_vld_ff <= '0;
      end else begin
         if (coef_we) begin
            coef_vld_ff[{req_bus.coef_table, IDX_W'(req_bus.coef_index)}] <= 1'b1;
         end
         if (hist_clr) begin
            hist_vld_ff <= '0;
         end else if (hist_we) begin
            hist_vld_ff[hist_waddr] <= 1'b1;
         end
      end
   end

   // Coefficient memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[{req_bus.coef_table, IDX_W'(req_bus.coef_index)}] <= req_bus.coef_value;
      end
      coef_rd_ff <= coef_mem[coef_raddr];
      coef_rv_ff <= coef_vld_ff[coef_raddr];
   end

   // History memory: shift write-back trails the reads toward older entries
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      hist_rd_ff <= hist_mem[hist_raddr];
      hist_rv_ff <= hist_vld_ff[hist_raddr];
   end

   // Multiply stage
   assign mul_a = tag1_ff.zero ? '0 : coef_eff;
   assign mul_b = (tag1_ff.op == OP_XB) ? sample_ff : hist_eff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         sample_ff <= req_bus.sample_in;
      end
      prod_ff <= mul_a * mul_b;
      if (tag1_ff.op == OP_DIV) begin
         div_ff <= coef_eff;
      end
   end

   // Accumulate stage
   always_ff @(posedge clock) begin
      if (acc_clr) begin
         acc_ff <= '0;
      end else if (tag2_op_ff == OP_ADD || tag2_op_ff == OP_XB) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end else if (tag2_op_ff == OP_SUB) begin
         acc_ff <= acc_ff - ACC_W'(prod_ff);
      end
   end

   // Divider: magnitudes, then one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (prep_go) begin
         aneg_ff <= acc_ff[ACC_W-1];
         qneg_ff <= acc_ff[ACC_W-1] ^ div_ff[DATA_W-1];
         mag_ff  <= acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
         dm_ff   <= div_ff[DATA_W-1] ? DATA_W'(-div_ff) : DATA_W'(div_ff);
      end
      if (div_init) begin
         rem_ff  <= mag_ff[2*DATA_W-1:DATA_W];
         quo_ff  <= mag_ff[DATA_W-1:0];
         dcnt_ff <= '0;
      end else if (div_step) begin
         rem_ff  <= rem_ge ? rem_diff[DATA_W-1:0] : rem2[DATA_W-1:0];
         quo_ff  <= {quo_ff[DATA_W-2:0], rem_ge};
         dcnt_ff <= dcnt_ff + 1'b1;
      end
   end

   // Result staging and output register payload
   always_ff @(posedge clock) begin
      if (res_load) begin
         res_y_ff  <= res_y_val;
         res_st_ff <= res_st_val;
      end
      if (rsp_load) begin
         rsp_y_ff  <= res_y_ff;
         rsp_st_ff <= res_st_ff;
      end
   end

   // Shift write-back never hits the entry read in the same cycle
   a_hist_rw_apart: assert property (@(posedge clock) disable iff (reset)
      hist_we && (issue_tag.op == OP_ADD || issue_tag.op == OP_SUB)
      |-> hist_waddr != hist_raddr)
      else $error("history write collides with read");

   // Partial remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> rem_ff < dm_ff)
      else $error("divider remainder out of range");

   // Accumulator pipe is empty before the magnitudes are taken
   a_pipe_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PREP |-> tag1_ff.op == OP_NONE && tag2_op_ff == OP_NONE)
      else $error("accumulator pipe not drained");

   // Output register is loaded only from the hand-over state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside hand-over");

   // Stored orders keep numerator order within denominator order
   a_order_rel: assert property (@(posedge clock) disable iff (reset)
      num_ord_ff <= den_ord_ff)
      else $error("numerator order above denominator order");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for discrete_transfer_function: directed and random command beats,
// with a scoreboard class that predicts every response in Q16.16 with exact wide sums.
// Depends on dtf_pkg, dtf_req_if, dtf_rsp_if and the discrete_transfer_function RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dtf_pkg::*;

   typedef struct {
      cmd_type                  cmd;
      logic                     enable;
      logic signed [DATA_W-1:0] sample;
      logic [ORDER_IN_W-1:0]    num_ord;
      logic [ORDER_IN_W-1:0]    den_ord;
      logic                     coef_sel;
      logic [COEF_IDX_W-1:0]    index;
      logic signed [DATA_W-1:0] value;
   } filter_req_t;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      status_type               st;
   } filter_result_t;

   // Tracks filter state and holds the responses still owed by the block
   class filter_scoreboard;
      logic signed [DATA_W-1:0] u_hist [MAX_ORDER+1];
      logic signed [DATA_W-1:0] y_hist [MAX_ORDER+1];
      logic signed [DATA_W-1:0] b_coef [MAX_ORDER+1];
      logic signed [DATA_W-1:0] a_coef [MAX_ORDER+1];
      int                       num_ord;
      int                       den_ord;
      filter_result_t           expected_q [$];
      int                       mismatch_count;

      function new();
         for (int i = 0; i <= MAX_ORDER; i++) begin
            u_hist[i] = '0;
            y_hist[i] = '0;
            b_coef[i] = '0;
            a_coef[i] = '0;
         end
         num_ord        = MAX_ORDER;
         den_ord        = MAX_ORDER;
         mismatch_count = 0;
      endfunction

      // Apply one command to the filter state and return the response it earns
      function filter_result_t filter_step(filter_req_t r);
         filter_result_t           res;
         logic signed [127:0]      acc;
         logic signed [127:0]      dwide;
         logic signed [DATA_W-1:0] b_i;
         logic [127:0]             mag;
         logic [127:0]             dmag;
         logic [127:0]             quo;
         logic [127:0]             lim;
         logic                     qneg;
         int                       n;
         res.value = '0;
         res.st    = ST_IDLE;
         case (r.cmd)
            CMD_SAMPLE: begin
               if (r.enable) begin
                  n   = den_ord;
                  acc = '0;
                  // exact Q32.32 sum; numerator taps above the order count as zero
                  for (int i = 0; i < n; i++) begin
                     b_i = (i <= num_ord) ? b_coef[i] : '0;
                     acc = acc + b_i * u_hist[n-1-i];
                     acc = acc - a_coef[i] * y_hist[n-1-i];
                  end
                  if (n <= num_ord) acc = acc + r.sample * b_coef[n];
                  if (a_coef[n] == '0) begin
                     // divide by zero: saturate toward the sign of the sum
                     res.st    = ST_SATURATED;
                     res.value = acc[127] ? SAT_MIN : SAT_MAX;
                  end else begin
                     dwide = a_coef[n];
                     qneg  = acc[127] ^ dwide[127];
                     mag   = acc[127] ? -acc : acc;
                     dmag  = dwide[127] ? -dwide : dwide;
                     quo   = mag / dmag;
                     lim   = qneg ? 128'h8000_0000 : 128'h7fff_ffff;
                     if (quo > lim) begin
                        res.st    = ST_SATURATED;
                        res.value = qneg ? SAT_MIN : SAT_MAX;
                     end else begin
                        res.st    = ST_COMPUTED;
                        res.value = qneg ? -quo[31:0] : quo[31:0];
                     end
                  end
                  // shift both histories up to the active order
                  for (int i = 0; i < n; i++) begin
                     u_hist[n-i] = u_hist[n-i-1];
                     y_hist[n-i] = y_hist[n-i-1];
                  end
                  u_hist[0] = r.sample;
                  y_hist[0] = res.value;
               end
            end
            CMD_SET_ORDERS: begin
               if (r.num_ord > MAX_ORDER || r.den_ord > MAX_ORDER || r.num_ord > r.den_ord) begin
                  res.st = ST_ORDERS_BAD;
               end else begin
                  num_ord = r.num_ord;
                  den_ord = r.den_ord;
                  res.st  = ST_ORDERS_OK;
               end
            end
            CMD_WRITE_COEF: begin
               if (r.index <= MAX_ORDER) begin
                  if (r.coef_sel == SEL_A) a_coef[r.index] = r.value;
                  else b_coef[r.index] = r.value;
               end
            end
            CMD_CLEAR: begin
               for (int i = 0; i <= MAX_ORDER; i++) begin
                  u_hist[i] = '0;
                  y_hist[i] = '0;
               end
            end
         endcase
         return res;
      endfunction

      function void note_request(filter_req_t r);
         expected_q.push_back(filter_step(r));
      endfunction

      function void check_response(logic signed [DATA_W-1:0] v, logic [STATUS_W-1:0] s);
         filter_result_t e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response, filter_out %0d status %0d", $time, v, s);
            mismatch_count++;
            return;
         end
         e = expected_q.pop_front();
         if (v !== e.value) begin
            $display("%0t: filter_out expected %0d actual %0d", $time, e.value, v);
            mismatch_count++;
         end
         if (s !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, s);
            mismatch_count++;
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   bit               steady;
   int unsigned      beats_sent;
   filter_scoreboard sb;

   dtf_req_if req_bus ();
   dtf_rsp_if rsp_bus ();

   discrete_transfer_function u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Throttle the response side, except in the steady stretch
   initial rsp_bus.ready = 1'b0;
   always @(negedge clock) begin
      rsp_bus.ready = reset ? 1'b0 : (steady || $urandom_range(99) >= 12);
   end

   // Check every response beat
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_response(rsp_bus.filter_out, rsp_bus.status);
   end

   // Drive one request beat, starting and ending just after a falling edge
   task automatic push_request(filter_req_t r);
      while (!steady && $urandom_range(99) < 12) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid        = 1'b1;
      req_bus.cmd          = r.cmd;
      req_bus.enable       = r.enable;
      req_bus.sample_in    = r.sample;
      req_bus.num_order_in = r.num_ord;
      req_bus.den_order_in = r.den_ord;
      req_bus.coef_table   = r.coef_sel;
      req_bus.coef_index   = r.index;
      req_bus.coef_value   = r.value;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(r);
      beats_sent++;
      @(negedge clock);
   endtask

   function automatic filter_req_t noise_req();
      filter_req_t r;
      r.cmd      = cmd_type'($urandom_range(3));
      r.enable   = $urandom;
      r.sample   = $urandom;
      r.num_ord  = $urandom;
      r.den_ord  = $urandom;
      r.coef_sel = $urandom;
      r.index    = $urandom;
      r.value    = $urandom;
      return r;
   endfunction

   task automatic send_sample(logic signed [DATA_W-1:0] x, logic en = 1'b1);
      filter_req_t r;
      r        = noise_req();
      r.cmd    = CMD_SAMPLE;
      r.enable = en;
      r.sample = x;
      push_request(r);
   endtask

   task automatic send_orders(logic [ORDER_IN_W-1:0] nn, logic [ORDER_IN_W-1:0] dn);
      filter_req_t r;
      r         = noise_req();
      r.cmd     = CMD_SET_ORDERS;
      r.num_ord = nn;
      r.den_ord = dn;
      push_request(r);
   endtask

   task automatic send_coef(logic sel, logic [COEF_IDX_W-1:0] idx, logic signed [DATA_W-1:0] v);
      filter_req_t r;
      r          = noise_req();
      r.cmd      = CMD_WRITE_COEF;
      r.coef_sel = sel;
      r.index    = idx;
      r.value    = v;
      push_request(r);
   endtask

   task automatic send_clear();
      filter_req_t r;
      r     = noise_req();
      r.cmd = CMD_CLEAR;
      push_request(r);
   endtask

   function automatic logic signed [DATA_W-1:0] spread(int unsigned mag);
      int t;
      t = int'($urandom_range(2 * mag)) - int'(mag);
      return t;
   endfunction

   // Leading denominator tap: mostly unity or moderate, sometimes zero or wild
   function automatic logic signed [DATA_W-1:0] pick_lead();
      int unsigned p;
      p = $urandom_range(99);
      if (p < 6) return '0;
      if (p < 12) return $urandom;
      if (p < 50) return 32'sh0001_0000;
      return $urandom_range(1) ? $urandom_range(32'h4000, 32'h40000)
                               : -$urandom_range(32'h4000, 32'h40000);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_tap(bit is_denom);
      if ($urandom_range(99) < 5) return $urandom;
      return is_denom ? spread(32'h8000) : spread(32'h18000);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_sample();
      int unsigned p;
      p = $urandom_range(99);
      if (p < 8) return $urandom;
      if (p < 10) return SAT_MAX;
      if (p < 12) return SAT_MIN;
      return spread(32'h20_0000);
   endfunction

   // One well-formed run: orders, coefficients, then a burst of samples mixed with noise
   task automatic run_phase();
      int unsigned den;
      int unsigned num;
      int unsigned p;
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(1, 4)) push_request(noise_req());
      end
      den = $urandom_range(MAX_ORDER);
      num = $urandom_range(den);
      send_orders(num, den);
      if ($urandom_range(3) == 0) send_clear();
      for (int i = 0; i <= den; i++) begin
         send_coef(SEL_A, i, (i == den) ? pick_lead() : pick_tap(1'b1));
         send_coef(SEL_B, i, pick_tap(1'b0));
      end
      // stray numerator taps above the order must not matter
      if (num < MAX_ORDER && $urandom_range(1)) send_coef(SEL_B, $urandom_range(num + 1, MAX_ORDER), $urandom);
      repeat ($urandom_range(8, 30)) begin
         p = $urandom_range(99);
         if (p < 5) send_orders($urandom_range(15), $urandom_range(15));
         else if (p < 9) send_coef($urandom, $urandom_range(MAX_ORDER + 1, 15), $urandom);
         else if (p < 13) send_sample(pick_sample(), 1'b0);
         else if (p < 15) send_clear();
         else send_sample(pick_sample());
      end
   endtask

   initial begin
      reset                = 1'b1;
      steady               = 1'b0;
      beats_sent           = 0;
      req_bus.valid        = 1'b0;
      req_bus.cmd          = CMD_SAMPLE;
      req_bus.enable       = 1'b0;
      req_bus.sample_in    = '0;
      req_bus.num_order_in = '0;
      req_bus.den_order_in = '0;
      req_bus.coef_table   = SEL_B;
      req_bus.coef_index   = '0;
      req_bus.coef_value   = '0;
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero coefficients after reset: divide by zero on a zero sum
      send_sample(SAT_MAX);
      send_sample(32'sh0001_0000, 1'b0);
      // rejected orders: too high, numerator above denominator
      send_orders(9, 9);
      send_orders(3, 2);
      send_orders(0, 15);
      send_orders(2, 2);
      send_coef(SEL_A, 15, 32'hdead_beef);
      send_coef(SEL_A, 2, 32'sh0001_0000);
      send_coef(SEL_B, 0, 32'sh0001_0000);
      send_coef(SEL_B, 1, -32'sh0000_8000);
      send_coef(SEL_B, 2, 32'sh0000_8000);
      send_coef(SEL_A, 0, -32'sh0000_4000);
      send_coef(SEL_A, 1, 32'sh0000_2000);
      send_sample(SAT_MAX);
      send_sample(SAT_MIN);
      send_sample(32'sh0001_0000);
      // overflow: a huge feed-through tap
      send_coef(SEL_B, 2, SAT_MAX);
      send_sample(SAT_MAX);
      // zero leading denominator with a negative sum
      send_coef(SEL_A, 2, '0);
      send_sample(SAT_MIN);
      // numerator order below denominator: b[2] is ignored
      send_orders(1, 2);
      send_coef(SEL_A, 2, -32'sh0002_0000);
      send_sample(32'sh0003_0000);
      send_clear();
      send_sample(32'sh0001_0000);

      // random runs, with one stretch of back-to-back traffic on both sides
      while (beats_sent < 880) begin
         steady = (beats_sent >= 400 && beats_sent < 550);
         run_phase();
      end
      steady        = 1'b0;
      req_bus.valid = 1'b0;

      // drain, then allow a late extra beat to show up
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.mismatch_count == 0) begin
         $display("discrete_transfer_function test passed");
      end else begin
         $display("discrete_transfer_function test failed");
      end
      $finish;
   end

   // Hard stop for a hung handshake
   initial begin
      #5_000_000;
      $display("discrete_transfer_function test failed");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/dtf_pkg.sv
hw/rtl/dtf_req_if.sv
hw/rtl/dtf_rsp_if.sv
hw/rtl/discrete_transfer_function.sv
verif/tb.sv
